### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/ffa_pkg.sv
// shared types, constants and micro-op codes for the free list allocator
package ffa_pkg;
	localparam int HEAP_UNITS = 65536;
	localparam int UNIT_BYTES = 16;
	localparam int UNIT_SH = $clog2(UNIT_BYTES);
	localparam int ADDR_W = $clog2(HEAP_UNITS);
	localparam int TOP_W = ADDR_W + 1;
	localparam int SIZE_W = ADDR_W + 1;
	localparam int REQ_W = 21;
	localparam int NU_W = REQ_W - UNIT_SH + 1;
	localparam int A_LIMIT = 2 * HEAP_UNITS + 4;
	localparam int A_CNT_W = $clog2(A_LIMIT + 1);
	localparam int PB_LIMIT = HEAP_UNITS;
	localparam int PB_CNT_W = $clog2(PB_LIMIT + 1);

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
	localparam logic [OP_W-1:0] OP_A_START  = 4'd2;
	localparam logic [OP_W-1:0] OP_A_GETP   = 4'd3;
	localparam logic [OP_W-1:0] OP_A_CHECK  = 4'd4;
	localparam logic [OP_W-1:0] OP_A_SPLIT  = 4'd5;
	localparam logic [OP_W-1:0] OP_A_RESUME = 4'd6;
	localparam logic [OP_W-1:0] OP_PB_START = 4'd7;
	localparam logic [OP_W-1:0] OP_PB_WALK  = 4'd8;
	localparam logic [OP_W-1:0] OP_PB_NEXT  = 4'd9;
	localparam logic [OP_W-1:0] OP_PB_MERGE = 4'd10;
	localparam logic [OP_W-1:0] OP_PB_RDP   = 4'd11;
	localparam logic [OP_W-1:0] OP_PB_PREV  = 4'd12;
	localparam logic [OP_W-1:0] OP_LOAD_OUT = 4'd13;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct packed {
		logic              action;
		logic [REQ_W-1:0]  request_bytes;
		logic [ADDR_W-1:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic              failed;
	} out_item_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} ffa_cmd_t;

	typedef struct packed {
		logic in_free;
		logic free_ok;
		logic a_ge;
		logic a_eq;
		logic a_at_rover;
		logic grow_fail;
		logic a_over;
		logic pb_stop;
		logic pb_over;
		logic pb_merge_n;
		logic from_grow;
	} ffa_status_t;
endpackage

### design/ffa_ctrl.sv
// sequencer for allocate, free and list insertion
module ffa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ffa_pkg::ffa_status_t st,
	output ffa_pkg::ffa_cmd_t    cmd
);
	import ffa_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_A_START  = 4'd1;
	localparam logic [3:0] S_A_GETP   = 4'd2;
	localparam logic [3:0] S_A_CHECK  = 4'd3;
	localparam logic [3:0] S_A_SPLIT  = 4'd4;
	localparam logic [3:0] S_A_RESUME = 4'd5;
	localparam logic [3:0] S_PB_START = 4'd6;
	localparam logic [3:0] S_PB_WALK  = 4'd7;
	localparam logic [3:0] S_PB_NEXT  = 4'd8;
	localparam logic [3:0] S_PB_MERGE = 4'd9;
	localparam logic [3:0] S_PB_RDP   = 4'd10;
	localparam logic [3:0] S_PB_PREV  = 4'd11;
	localparam logic [3:0] S_DONE     = 4'd12;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic [3:0] ret_state;

	assign ret_state = st.from_grow ? S_A_RESUME : S_DONE;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_ACCEPT;
					if (st.in_free)
						state_d = st.free_ok ? S_PB_START : S_DONE;
					else
						state_d = S_A_START;
				end
			end
			S_A_START: begin
				cmd.op  = OP_A_START;
				state_d = S_A_GETP;
			end
			S_A_GETP: begin
				cmd.op  = OP_A_GETP;
				state_d = S_A_CHECK;
			end
			S_A_CHECK: begin
				cmd.op = OP_A_CHECK;
				if (st.a_ge)
					state_d = st.a_eq ? S_DONE : S_A_SPLIT;
				else if (st.a_at_rover)
					state_d = st.grow_fail ? S_DONE : S_PB_START;
				else if (st.a_over)
					state_d = S_DONE;
			end
			S_A_SPLIT: begin
				cmd.op  = OP_A_SPLIT;
				state_d = S_DONE;
			end
			S_A_RESUME: begin
				cmd.op  = OP_A_RESUME;
				state_d = st.a_over ? S_DONE : S_A_GETP;
			end
			S_PB_START: begin
				cmd.op  = OP_PB_START;
				state_d = S_PB_WALK;
			end
			S_PB_WALK: begin
				cmd.op = OP_PB_WALK;
				if (st.pb_stop)
					state_d = S_PB_NEXT;
				else if (st.pb_over)
					state_d = ret_state;
			end
			S_PB_NEXT: begin
				cmd.op  = OP_PB_NEXT;
				state_d = st.pb_merge_n ? S_PB_MERGE : S_PB_PREV;
			end
			S_PB_MERGE: begin
				cmd.op  = OP_PB_MERGE;
				state_d = S_PB_RDP;
			end
			S_PB_RDP: begin
				cmd.op  = OP_PB_RDP;
				state_d = S_PB_PREV;
			end
			S_PB_PREV: begin
				cmd.op  = OP_PB_PREV;
				state_d = ret_state;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_LOAD_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

### design/ffa_datapath.sv
// link and size memories, walk registers and output register
module ffa_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffa_pkg::in_item_t    in_item,
	input  ffa_pkg::ffa_cmd_t    cmd,
	output ffa_pkg::ffa_status_t st,
	output ffa_pkg::out_item_t   out_item
);
	import ffa_pkg::*;

	logic [ADDR_W-1:0] link_mem [HEAP_UNITS];
	logic [SIZE_W-1:0] size_mem [HEAP_UNITS];

	logic [ADDR_W-1:0] link_dout_q, link_ra_q, size_ra_q;
	logic [SIZE_W-1:0] size_dout_q;
	logic              link0_wr_q, size0_wr_q;

	logic [ADDR_W-1:0] rover_q, p_q, prev_q, bp_q, nx_q, lbp_q;
	logic [TOP_W-1:0]  heap_top_q;
	logic [NU_W-1:0]   nunits_q;
	logic [SIZE_W-1:0] sb_q;
	logic [A_CNT_W-1:0]  a_steps_q;
	logic [PB_CNT_W-1:0] pb_steps_q;
	logic              from_grow_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_fail_q;
	out_item_t         out_q;

	logic              link_we, size_we;
	logic [ADDR_W-1:0] link_addr, size_addr, link_wdata;
	logic [SIZE_W-1:0] size_wdata;

	logic [ADDR_W-1:0] link_rd;
	logic [SIZE_W-1:0] size_rd;
	logic [REQ_W:0]    nu_sum;
	logic [NU_W-1:0]   nu_calc;
	logic [SIZE_W-1:0] rest;
	logic [ADDR_W-1:0] split_q;
	logic [TOP_W+1:0]  grow_sum;
	logic [SIZE_W:0]   bp_end, p_end;
	logic [SIZE_W-1:0] merge_sum;
	logic              merge_p;

	// unit 0 reads as zero size and a self link until written
	assign link_rd = (link_ra_q == '0 && !link0_wr_q) ? '0 : link_dout_q;
	assign size_rd = (size_ra_q == '0 && !size0_wr_q) ? '0 : size_dout_q;

	assign nu_sum  = {1'b0, in_item.request_bytes} + (REQ_W+1)'(UNIT_BYTES - 1);
	assign nu_calc = NU_W'(nu_sum >> UNIT_SH) + NU_W'(1);

	assign rest     = size_rd - nunits_q[SIZE_W-1:0];
	assign split_q  = p_q + rest[ADDR_W-1:0];
	assign grow_sum = {2'b00, heap_top_q} + (TOP_W+2)'(nunits_q);
	assign bp_end   = {2'b00, bp_q} + {1'b0, size_rd};
	assign p_end    = {2'b00, p_q} + {1'b0, size_rd};
	assign merge_sum = sb_q + size_rd;
	assign merge_p  = (p_end == {2'b00, bp_q});

	always_comb begin
		st.in_free    = (in_item.action == ACT_FREE);
		st.free_ok    = (in_item.block_address >= ADDR_W'(2)) &&
			(({1'b0, in_item.block_address} - TOP_W'(1)) < heap_top_q);
		st.a_ge       = ({1'b0, size_rd} >= nunits_q);
		st.a_eq       = ({1'b0, size_rd} == nunits_q);
		st.a_at_rover = (p_q == rover_q);
		st.grow_fail  = (grow_sum > (TOP_W+2)'(HEAP_UNITS));
		st.a_over     = (a_steps_q >= A_CNT_W'(A_LIMIT));
		st.pb_stop    = (bp_q > p_q && bp_q < link_rd) ||
			(p_q >= link_rd && (bp_q > p_q || bp_q < link_rd));
		st.pb_over    = (pb_steps_q >= PB_CNT_W'(PB_LIMIT));
		st.pb_merge_n = (bp_end == {2'b00, nx_q});
		st.from_grow  = from_grow_q;
	end

	// memory port selection per micro-op
	always_comb begin
		link_we    = 1'b0;
		size_we    = 1'b0;
		link_addr  = rover_q;
		size_addr  = p_q;
		link_wdata = '0;
		size_wdata = '0;
		case (cmd.op)
			OP_A_START, OP_A_RESUME, OP_PB_START: link_addr = rover_q;
			OP_A_GETP: begin
				link_addr = link_rd;
				size_addr = link_rd;
			end
			OP_A_CHECK: begin
				if (st.a_ge) begin
					if (st.a_eq) begin
						link_we    = 1'b1;
						link_addr  = prev_q;
						link_wdata = link_rd;
					end else begin
						size_we    = 1'b1;
						size_addr  = p_q;
						size_wdata = rest;
					end
				end else if (st.a_at_rover) begin
					size_we    = !st.grow_fail;
					size_addr  = heap_top_q[ADDR_W-1:0];
					size_wdata = nunits_q[SIZE_W-1:0];
				end else begin
					link_addr = link_rd;
					size_addr = link_rd;
				end
			end
			OP_A_SPLIT: begin
				size_we    = 1'b1;
				size_addr  = p_q;
				size_wdata = nunits_q[SIZE_W-1:0];
			end
			OP_PB_WALK: begin
				link_addr = link_rd;
				size_addr = bp_q;
			end
			OP_PB_NEXT: begin
				if (st.pb_merge_n) begin
					link_addr = nx_q;
					size_addr = nx_q;
				end else begin
					link_we    = 1'b1;
					link_addr  = bp_q;
					link_wdata = nx_q;
					size_addr  = p_q;
				end
			end
			OP_PB_MERGE: begin
				link_we    = 1'b1;
				link_addr  = bp_q;
				link_wdata = link_rd;
				size_we    = 1'b1;
				size_addr  = bp_q;
				size_wdata = merge_sum;
			end
			OP_PB_RDP: size_addr = p_q;
			OP_PB_PREV: begin
				link_we   = 1'b1;
				link_addr = p_q;
				if (merge_p) begin
					link_wdata = lbp_q;
					size_we    = 1'b1;
					size_addr  = p_q;
					size_wdata = size_rd + sb_q;
				end else begin
					link_wdata = bp_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_addr] <= link_wdata;
		else begin
			link_dout_q <= link_mem[link_addr];
			link_ra_q   <= link_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (size_we)
			size_mem[size_addr] <= size_wdata;
		else begin
			size_dout_q <= size_mem[size_addr];
			size_ra_q   <= size_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link0_wr_q <= 1'b0;
			size0_wr_q <= 1'b0;
			rover_q    <= '0;
			heap_top_q <= TOP_W'(1);
		end else begin
			if (link_we && link_addr == '0)
				link0_wr_q <= 1'b1;
			if (size_we && size_addr == '0)
				size0_wr_q <= 1'b1;
			case (cmd.op)
				OP_A_CHECK: begin
					if (st.a_ge && st.a_eq)
						rover_q <= prev_q;
					else if (!st.a_ge && st.a_at_rover && !st.grow_fail)
						heap_top_q <= grow_sum[TOP_W-1:0];
				end
				OP_A_SPLIT: rover_q <= prev_q;
				OP_PB_PREV: rover_q <= p_q;
				default: ;
			endcase
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				from_grow_q <= 1'b0;
				bp_q        <= in_item.block_address - ADDR_W'(1);
				nunits_q    <= nu_calc;
				res_addr_q  <= '0;
				res_fail_q  <= 1'b0;
			end
			OP_A_START: begin
				prev_q    <= rover_q;
				a_steps_q <= '0;
			end
			OP_A_GETP: p_q <= link_rd;
			OP_A_CHECK: begin
				if (st.a_ge) begin
					if (st.a_eq)
						res_addr_q <= p_q + ADDR_W'(1);
					else
						p_q <= split_q;
				end else if (st.a_at_rover) begin
					if (st.grow_fail)
						res_fail_q <= 1'b1;
					else begin
						bp_q        <= heap_top_q[ADDR_W-1:0];
						from_grow_q <= 1'b1;
					end
				end else if (st.a_over) begin
					res_fail_q <= 1'b1;
				end else begin
					prev_q    <= p_q;
					p_q       <= link_rd;
					a_steps_q <= a_steps_q + A_CNT_W'(1);
				end
			end
			OP_A_SPLIT: res_addr_q <= p_q + ADDR_W'(1);
			OP_A_RESUME: begin
				if (st.a_over)
					res_fail_q <= 1'b1;
				prev_q    <= rover_q;
				a_steps_q <= a_steps_q + A_CNT_W'(1);
			end
			OP_PB_START: begin
				p_q        <= rover_q;
				pb_steps_q <= '0;
			end
			OP_PB_WALK: begin
				if (st.pb_stop)
					nx_q <= link_rd;
				else begin
					p_q        <= link_rd;
					pb_steps_q <= pb_steps_q + PB_CNT_W'(1);
				end
			end
			OP_PB_NEXT: begin
				sb_q  <= size_rd;
				lbp_q <= nx_q;
			end
			OP_PB_MERGE: begin
				sb_q  <= merge_sum;
				lbp_q <= link_rd;
			end
			OP_LOAD_OUT: begin
				out_q.result_address <= res_addr_q;
				out_q.failed         <= res_fail_q;
			end
			default: ;
		endcase
	end

	assign out_item = out_q;
endmodule

### design/first_fit_free_list_allocator_unit.sv
// top level of the first-fit free list allocator
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_item  (action, request_bytes, block_address)
//  out     | output    | out_valid / out_ready| out_item (result_address, failed)
//
// one item at a time; an allocate walks the free list from the rover until a block fits,
// a free walks the list from the rover to its insert point
// a heap growth adds one insertion walk to the allocate; the list walk in the
// single-port link and size memories sets the pace
// reset clears control and rover, sets the heap top to 1; memories need no clearing pass
// a new item is taken while the previous result waits in the output register
module first_fit_free_list_allocator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ffa_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ffa_pkg::out_item_t out_item
);
	import ffa_pkg::*;

	ffa_cmd_t    cmd;
	ffa_status_t st;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ffa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.st       (st),
		.out_item (out_item)
	);
endmodule

### design/ffa_checker.sv
// port-level checks for the allocator, bound to the top level
`include "assert_macros.svh"

module ffa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input ffa_pkg::out_item_t out_item,
	input logic               out_valid,
	input logic               out_ready
);
	import ffa_pkg::*;

	// a waiting result holds its value
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))
	// a failed allocate never reports an address
	`CHK_SAME(a_fail_no_addr, clk, arst_n, out_valid && out_item.failed, out_item.result_address == '0)
	// one item in flight: taking an item closes the input for the next cycle
	`CHK_NEXT(a_one_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	// a result only shows up after the block has been busy
	`CHK_SAME(a_res_after_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))
endmodule

bind first_fit_free_list_allocator_unit ffa_checker u_ffa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_item  (out_item),
	.out_valid (out_valid),
	.out_ready (out_ready)
);

### verif/first_fit_free_list_allocator_unit_tb.sv
// testbench for the first-fit free list allocator: directed and random alloc/free traffic
module first_fit_free_list_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffa_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 600;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	first_fit_free_list_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// shadow of the heap: links, sizes, rover and top
	logic [ADDR_W-1:0] shadow_link [HEAP_UNITS];
	logic [SIZE_W-1:0] shadow_size [HEAP_UNITS];
	logic [ADDR_W-1:0] shadow_rover;
	logic [TOP_W-1:0]  shadow_top;

	out_item_t   pending_results[$];
	logic [15:0] live_blocks[$];
	int          error_count;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          alloc_count;
	int          free_count;
	int          fail_count;
	int          result_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic void insert_block(input int bp);
		int p;
		int nx;
		longint steps;
		p = shadow_rover;
		steps = 0;
		while (!(bp > p && bp < int'(shadow_link[p]))) begin
			if (p >= int'(shadow_link[p]) && (bp > p || bp < int'(shadow_link[p])))
				break;
			p = shadow_link[p];
			steps++;
			if (steps > HEAP_UNITS)
				return;
		end
		nx = shadow_link[p];
		if (bp + int'(shadow_size[bp]) == nx) begin
			shadow_size[bp] = shadow_size[bp] + shadow_size[nx];
			shadow_link[bp] = shadow_link[nx];
		end else begin
			shadow_link[bp] = nx[ADDR_W-1:0];
		end
		if (p + int'(shadow_size[p]) == bp) begin
			shadow_size[p] = shadow_size[p] + shadow_size[bp];
			shadow_link[p] = shadow_link[bp];
		end else begin
			shadow_link[p] = bp[ADDR_W-1:0];
		end
		shadow_rover = p[ADDR_W-1:0];
	endfunction

	function automatic bit grow_heap(input int nu);
		int b;
		if (int'(shadow_top) + nu > HEAP_UNITS)
			return 1'b0;
		b = shadow_top;
		shadow_size[b] = nu[SIZE_W-1:0];
		shadow_top = shadow_top + nu[TOP_W-1:0];
		insert_block(b);
		return 1'b1;
	endfunction

	function automatic out_item_t serve_request(input in_item_t it);
		out_item_t r;
		int nunits;
		int prev;
		int p;
		longint steps;
		r = '0;
		if (it.action == ACT_FREE) begin
			if (it.block_address >= 2 && int'(it.block_address) - 1 < int'(shadow_top))
				insert_block(int'(it.block_address) - 1);
			return r;
		end
		nunits = (int'(it.request_bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
		prev = shadow_rover;
		p = shadow_link[prev];
		steps = 0;
		forever begin
			if (int'(shadow_size[p]) >= nunits) begin
				if (int'(shadow_size[p]) == nunits) begin
					shadow_link[prev] = shadow_link[p];
				end else begin
					shadow_size[p] = shadow_size[p] - nunits[SIZE_W-1:0];
					p = (p + int'(shadow_size[p])) % HEAP_UNITS;
					shadow_size[p] = nunits[SIZE_W-1:0];
				end
				shadow_rover = prev[ADDR_W-1:0];
				r.result_address = p[ADDR_W-1:0] + 1'b1;
				return r;
			end
			if (p == int'(shadow_rover)) begin
				if (!grow_heap(nunits)) begin
					r.failed = 1'b1;
					return r;
				end
				p = shadow_rover;
			end
			prev = p;
			p = shadow_link[p];
			steps++;
			if (steps > 2 * HEAP_UNITS + 4) begin
				r.failed = 1'b1;
				return r;
			end
		end
	endfunction

	task automatic send_item(input in_item_t it);
		out_item_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		r = serve_request(it);
		pending_results.push_back(r);
		if (it.action == ACT_FREE) begin
			free_count++;
		end else begin
			alloc_count++;
			if (r.failed)
				fail_count++;
			else
				live_blocks.push_back(r.result_address);
		end
	endtask

	task automatic alloc_bytes(input int nbytes);
		in_item_t it;
		it.action = ACT_ALLOC;
		it.request_bytes = nbytes[REQ_W-1:0];
		it.block_address = $urandom_range(16'hFFFF);
		send_item(it);
	endtask

	task automatic free_addr(input int addr);
		in_item_t it;
		it.action = ACT_FREE;
		it.request_bytes = $urandom_range(21'h1FFFFF);
		it.block_address = addr[ADDR_W-1:0];
		send_item(it);
	endtask

	task automatic free_live(input int idx);
		int a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		free_addr(a);
	endtask

	task automatic wait_drained();
		// the last item is already taken, so drop valid before the block goes idle
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// zero bytes, unit boundaries, merge on both sides, exact-fit reuse
	task automatic test_basic_alloc_free();
		int n;
		alloc_bytes(0);
		alloc_bytes(1);
		alloc_bytes(16);
		alloc_bytes(17);
		alloc_bytes(48);
		n = live_blocks.size();
		free_live(n - 4);
		free_live(n - 3);
		free_live(n - 4);
		alloc_bytes(17);
		alloc_bytes(100);
		while (live_blocks.size() != 0)
			free_live(0);
	endtask

	// ignored frees: base and out-of-heap addresses
	task automatic test_bad_free();
		free_addr(0);
		free_addr(1);
		free_addr(16'hFFFF);
		free_addr(int'(shadow_top) + 1);
	endtask

	// heap exhaustion and the largest request
	task automatic test_exhaustion();
		alloc_bytes(1048576);
		alloc_bytes(1048575);
		alloc_bytes(900000);
		alloc_bytes(200000);
		while (live_blocks.size() != 0)
			free_live(0);
		alloc_bytes(64);
	endtask

	task automatic test_random_traffic(input int nitems, input int s_pct, input int r_pct);
		int k;
		int sel;
		int a;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (k = 0; k < nitems; k++) begin
			sel = $urandom_range(99);
			if (k == nitems / 2) begin
				// hold off until the block has answered everything
				wait_drained();
			end
			if (sel < 6) begin
				case ($urandom_range(2))
					0: free_addr($urandom_range(1));
					1: begin
						// only outside the heap while the top is below that header
						if (int'(shadow_top) < 16'hFFFF)
							free_addr(16'hFFFF);
						else
							free_addr(1);
					end
					default: begin
						a = int'(shadow_top) + 1 + int'($urandom_range(100));
						if (a <= 16'hFFFF)
							free_addr(a);
						else
							free_addr(0);
					end
				endcase
			end else if (sel < 50 && live_blocks.size() != 0) begin
				free_live($urandom_range(live_blocks.size() - 1));
			end else if (sel < 53) begin
				alloc_bytes($urandom_range(1048576, 400000));
			end else if (sel < 60) begin
				alloc_bytes($urandom_range(8192));
			end else begin
				alloc_bytes($urandom_range(256));
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item, address", out_item.result_address, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_item.result_address !== want.result_address)
					report_mismatch("result_address", out_item.result_address,
						want.result_address);
				if (out_item.failed !== want.failed)
					report_mismatch("failed", out_item.failed, want.failed);
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int i;
		for (i = 0; i < HEAP_UNITS; i++) begin
			shadow_link[i] = '0;
			shadow_size[i] = '0;
		end
		shadow_rover = '0;
		shadow_top = 1;
		error_count = 0;
		cycle_count = 0;
		alloc_count = 0;
		free_count = 0;
		fail_count = 0;
		result_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 8;
		recv_idle_pct = 74;
		test_basic_alloc_free();
		test_bad_free();
		test_exhaustion();
		test_random_traffic(300, 8, 74);
		test_random_traffic(280, 74, 8);
		test_random_traffic(270, 0, 0);
		@(negedge clk);
		in_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d allocates (%0d failed) and %0d frees, %0d results checked",
			alloc_count, fail_count, free_count, result_count);
		$display("heap top ended at unit %0d with %0d blocks still live", shadow_top,
			live_blocks.size());
		if (error_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

### filelist.f
+incdir+design
design/ffa_pkg.sv
design/ffa_ctrl.sv
design/ffa_datapath.sv
design/first_fit_free_list_allocator_unit.sv
design/ffa_checker.sv
verif/first_fit_free_list_allocator_unit_tb.sv
